// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int FUNC_W        = 3;
  localparam int DATA_W        = 32;
  localparam int STATUS_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_LIST_FWD   = 3'd4,
    FUNC_LIST_BWD   = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed words held in a ring buffer.
//
// Each transfer on the input channel (in_valid, in_ready, func, value) asks for
// one operation: push or pop at either end, or a listing in either direction.
// Results leave on the output channel (out_valid, out_ready, status, item,
// last). A push or pop gives one result in the cycle after its transfer; a
// listing gives one result per stored entry, since each entry is fetched
// through the single read port of the ring memory before it is shown, or a
// single empty status on an empty queue. An unused func code is absorbed and
// gives no result. One item is handled at a time: in_ready is high only while
// the sequencer is idle, which it is again once the last result is taken.
// A stalled receiver simply holds the current result in the output register;
// nothing is lost and the sequencer waits. Reset empties the queue and sets
// the front index to zero; the memory itself is not cleared, as only written
// entries are ever read.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [deq_pkg::FUNC_W-1:0]          func,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic signed [deq_pkg::DATA_W-1:0]   item,
  output logic                                last
);

  import deq_pkg::*;

  localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RESP = 4'b0010,
    S_READ = 4'b0100,
    S_SHOW = 4'b1000
  } state_t;

  state_t          state;
  logic [IW-1:0]   front;
  logic [CW-1:0]   count;
  logic [IW-1:0]   ptr;
  logic [CW-1:0]   remaining;
  logic            list_fwd;
  logic [DATA_W-1:0] mem [DEPTH];

  logic            accept;
  logic            full;
  logic            empty;
  logic [IW-1:0]   front_dec;
  logic [IW-1:0]   front_inc;
  logic [IW-1:0]   back_pos;
  logic [IW-1:0]   tail_pos;
  logic [IW-1:0]   wr_addr;
  logic            wr_en;

  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_dec(logic [IW-1:0] p);
    return (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP) || (state == S_SHOW);
  assign accept    = in_valid && in_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = ring_dec(front);
  assign front_inc = ring_inc(front);
  assign tail_pos  = ring_add(front, count);
  assign back_pos  = ring_add(front, count - 1'b1);

  always_comb begin
    wr_addr = (func == FUNC_PUSH_FRONT) ? front_dec : tail_pos;
    wr_en   = accept && !full && (func inside {FUNC_PUSH_FRONT, FUNC_PUSH_BACK});
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '0;
    end else if (state == S_READ) begin
      item <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      ptr       <= '0;
      remaining <= '0;
      list_fwd  <= 1'b1;
      status    <= STATUS_OK;
      last      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last   <= 1'b1;
            status <= STATUS_OK;
            if (func inside {FUNC_PUSH_FRONT, FUNC_PUSH_BACK}) begin
              state <= S_RESP;
              if (full) begin
                status <= STATUS_FULL;
              end else begin
                count <= count + 1'b1;
                if (func == FUNC_PUSH_FRONT) begin
                  front <= front_dec;
                end
              end
            end else if (func inside {FUNC_POP_FRONT, FUNC_POP_BACK}) begin
              state <= S_RESP;
              if (empty) begin
                status <= STATUS_EMPTY;
              end else begin
                count <= count - 1'b1;
                if (func == FUNC_POP_FRONT) begin
                  front <= front_inc;
                end
              end
            end else if (func inside {FUNC_LIST_FWD, FUNC_LIST_BWD}) begin
              if (empty) begin
                status <= STATUS_EMPTY;
                state  <= S_RESP;
              end else begin
                list_fwd  <= (func == FUNC_LIST_FWD);
                ptr       <= (func == FUNC_LIST_FWD) ? front : back_pos;
                remaining <= count;
                state     <= S_READ;
              end
            end
          end
        end
        S_RESP: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          ptr       <= list_fwd ? ring_inc(ptr) : ring_dec(ptr);
          remaining <= remaining - 1'b1;
          last      <= (remaining == CW'(1));
          state     <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready) begin
            state <= (remaining == '0) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/deq_checker.sv =====
// Checker for the double-ended queue: predicts results per input transfer and compares them.
`timescale 1ns / 1ps

module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [deq_pkg::FUNC_W-1:0]          func,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [deq_pkg::STATUS_W-1:0]        status,
  input  logic signed [deq_pkg::DATA_W-1:0]   item,
  input  logic                                last,
  output int                                  fail_count,
  output int                                  pending
);

  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  item;
    logic                      last;
  } deq_result_t;

  logic signed [DATA_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]         head;
  logic [IDX_W:0]           fill;
  deq_result_t              expected_q [$];

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic predict_op(input logic [FUNC_W-1:0] f,
                            input logic signed [DATA_W-1:0] v);
    int off;
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          expected_q.push_back('{STATUS_FULL, '0, 1'b1});
        end else begin
          if (f == FUNC_PUSH_FRONT) begin
            head = IDX_W'((head + DEPTH - 1) % DEPTH);
            ring[head] = v;
          end else begin
            ring[IDX_W'((head + fill) % DEPTH)] = v;
          end
          fill++;
          expected_q.push_back('{STATUS_OK, '0, 1'b1});
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (fill == 0) begin
          expected_q.push_back('{STATUS_EMPTY, '0, 1'b1});
        end else begin
          if (f == FUNC_POP_FRONT) head = IDX_W'((head + 1) % DEPTH);
          fill--;
          expected_q.push_back('{STATUS_OK, '0, 1'b1});
        end
      end
      FUNC_LIST_FWD, FUNC_LIST_BWD: begin
        if (fill == 0) begin
          expected_q.push_back('{STATUS_EMPTY, '0, 1'b1});
        end else begin
          for (int i = 0; i < fill; i++) begin
            off = (f == FUNC_LIST_FWD) ? i : fill - 1 - i;
            expected_q.push_back('{STATUS_OK, ring[IDX_W'((head + off) % DEPTH)],
                                   i == fill - 1});
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    deq_result_t want;
    if (rst) begin
      head = '0;
      fill = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d item %0d last %0b",
                                 status, item, last));
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status || item !== want.item || last !== want.last)
            note_failure($sformatf(
              "mismatch: expected status %0d item %0d last %0b, got status %0d item %0d last %0b",
              want.status, want.item, want.last, status, item, last));
        end
      end
      if (in_valid && in_ready) predict_op(func, value);
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the double-ended queue: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func;
  logic signed [DATA_W-1:0]  value;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       status;
  logic signed [DATA_W-1:0]  item;
  logic                      last;
  int                        fail_count;
  int                        pending;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        hold_off_len;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .item(item), .last(last)
  );

  deq_checker #(.DEPTH(DEPTH)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .item(item), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // A nonzero hold_off_len keeps out_ready low for a long hold-off, then is cleared.
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        out_ready <= 1'b0;
        for (int k = 0; k < hold_off_len; k++) @(posedge clk);
        hold_off_len = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int push_pct, input int pop_pct);
    int r;
    logic [FUNC_W-1:0] f;
    r = $urandom_range(99);
    if (r < push_pct)
      f = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    else if (r < push_pct + pop_pct)
      f = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    else if (r < 96)
      f = $urandom_range(1) ? FUNC_LIST_BWD : FUNC_LIST_FWD;
    else
      f = $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    send_op(f, $urandom);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = '0;
    value          = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue, spare codes, and the sole entry leaving by either end.
    send_op(FUNC_POP_FRONT, 32'sd5);
    send_op(FUNC_POP_BACK, 32'sd5);
    send_op(FUNC_LIST_FWD, '0);
    send_op(FUNC_LIST_BWD, '0);
    send_op(FUNC_SPARE_LO, 32'h1234_5678);
    send_op(FUNC_SPARE_HI, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH_BACK, 32'h7FFF_FFFF);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_PUSH_FRONT, 32'h8000_0000);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH_BACK, '0);
    send_op(FUNC_PUSH_FRONT, 32'h8000_0000);
    send_op(FUNC_PUSH_BACK, 32'h7FFF_FFFF);
    send_op(FUNC_PUSH_FRONT, 32'sd1);
    send_op(FUNC_LIST_FWD, '0);
    send_op(FUNC_LIST_BWD, '0);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_LIST_FWD, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_FRONT, '0);

    // Fill past capacity so that the last pushes are refused.
    repeat (DEPTH + 4) send_random(100, 0);

    // The receiver holds off while a full listing and further items are offered.
    hold_off_len = 120;
    send_op(FUNC_LIST_FWD, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_PUSH_FRONT, $urandom);
    send_op(FUNC_PUSH_BACK, $urandom);
    send_op(FUNC_LIST_BWD, '0);
    wait_drained();

    send_idle_pct  = 55;
    recv_stall_pct = 0;
    repeat (50) send_random(30, 55);

    send_idle_pct  = 0;
    recv_stall_pct = 55;
    repeat (50) send_random(55, 30);

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    repeat (50) send_random(42, 42);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
rtl/deq_pkg.sv
rtl/double_ended_queue.sv
tb/deq_checker.sv
tb/tb_top.sv
